// ----- hw/rtl/config_token_classifier_top_macros.svh -----
// ----------------------------------------------------------------------------
// config_token_classifier_top_macros
// assertion macros used by the checker file
// ----------------------------------------------------------------------------
`ifndef CONFIG_TOKEN_CLASSIFIER_TOP_MACROS_SVH
`define CONFIG_TOKEN_CLASSIFIER_TOP_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define CTC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define CTC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hw/rtl/ctc_pkg.sv -----
// ----------------------------------------------------------------------------
// ctc_pkg
// types, codes and keyword tables of the configuration token classifier
// ----------------------------------------------------------------------------
package ctc_pkg;

	localparam int MAX_LENGTH = 255;
	localparam int CNT_W      = $clog2(MAX_LENGTH + 1);
	localparam int LEN_W      = 8;
	localparam int CLS_W      = 5;
	localparam int NUM_KW     = 17;
	localparam int KW_MAX_LEN = 20;
	localparam int KW_IDX_W   = $clog2(KW_MAX_LEN);
	localparam int OQ_DEPTH   = 4;
	localparam int OQ_PTR_W   = $clog2(OQ_DEPTH);
	localparam int OQ_CNT_W   = $clog2(OQ_DEPTH + 1);

	typedef enum logic [CLS_W-1:0] {
		CLS_END         = 5'd0,
		CLS_SRV_NAME    = 5'd1,
		CLS_LISTEN      = 5'd2,
		CLS_ERR_PAGE    = 5'd3,
		CLS_BODY_MAX    = 5'd4,
		CLS_LOCATION    = 5'd5,
		CLS_ALLOW       = 5'd6,
		CLS_METHOD      = 5'd7,
		CLS_REDIRECT    = 5'd8,
		CLS_ROOT        = 5'd9,
		CLS_AUTOINDEX   = 5'd10,
		CLS_ON_OFF      = 5'd11,
		CLS_DEFAULT     = 5'd12,
		CLS_EXTENSION   = 5'd13,
		CLS_CGI         = 5'd14,
		CLS_UPLOAD      = 5'd15,
		CLS_LBRACE      = 5'd16,
		CLS_RBRACE      = 5'd17,
		CLS_NUMBER      = 5'd18,
		CLS_SEMI        = 5'd19,
		CLS_OTHER       = 5'd20
	} tok_cls_t;

	// shape flag bit positions
	localparam int SH_DIGITS = 0;
	localparam int SH_ZERO0  = 1;
	localparam int SH_DOT0   = 2;
	localparam int SH_DOT2   = 3;
	localparam logic [3:0] SHAPE_RESET = 4'b0001;

	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;

	// keywords in match priority order, right-justified
	localparam logic [KW_MAX_LEN*8-1:0] KW_STR [NUM_KW] = '{
		{"server_", "name"}, "listen", {"error_", "page"}, {"client_body_", "size_max"},
		"location", {"allow_", "methods"}, "GET", "POST", "DELETE", "redirect",
		"root", "autoindex", "on", "off", "default", "cgi", "upload"
	};

	localparam int KW_LEN [NUM_KW] = '{
		11, 6, 10, 20, 8, 13, 3, 4, 6, 8, 4, 9, 2, 3, 7, 3, 6
	};

	localparam tok_cls_t KW_CLS [NUM_KW] = '{
		CLS_SRV_NAME, CLS_LISTEN, CLS_ERR_PAGE, CLS_BODY_MAX,
		CLS_LOCATION, CLS_ALLOW, CLS_METHOD, CLS_METHOD, CLS_METHOD,
		CLS_REDIRECT, CLS_ROOT, CLS_AUTOINDEX, CLS_ON_OFF, CLS_ON_OFF,
		CLS_DEFAULT, CLS_CGI, CLS_UPLOAD
	};

	typedef struct packed {
		tok_cls_t         cls;
		logic [LEN_W-1:0] len;
		logic             last;
	} res_t;

	typedef struct packed {
		logic [1:0] num;
		res_t       r0;
		res_t       r1;
	} lex_out_t;

	// character of keyword k at position pos, zero past its end
	function automatic logic [7:0] kw_char(input int k, input logic [KW_IDX_W-1:0] pos);
		int sh;
		sh = 8 * (KW_LEN[k] - 1 - int'(pos));
		if (int'(pos) < KW_LEN[k]) begin
			return KW_STR[k][sh +: 8];
		end
		return 8'h00;
	endfunction

	function automatic logic [LEN_W-1:0] sat_len(input logic [CNT_W-1:0] cnt);
		if (32'(cnt) > 32'(2 ** LEN_W - 1)) begin
			return '1;
		end
		return LEN_W'(cnt);
	endfunction

endpackage

// ----- hw/rtl/ctc_if.sv -----
// ----------------------------------------------------------------------------
// ctc_if
// valid/ready channels of the configuration token classifier
// ----------------------------------------------------------------------------
interface ctc_in_if import ctc_pkg::*;;
	logic       valid;
	logic       ready;
	logic [7:0] byte_in;
	logic       end_of_text;

	modport source (output valid, output byte_in, output end_of_text, input ready);
	modport sink (input valid, input byte_in, input end_of_text, output ready);
endinterface

interface ctc_out_if import ctc_pkg::*;;
	logic             valid;
	logic             ready;
	logic [CLS_W-1:0] token_class;
	logic [LEN_W-1:0] token_length;
	logic             last;

	modport source (output valid, output token_class, output token_length, output last,
		input ready);
	modport sink (input valid, input token_class, input token_length, input last,
		output ready);
endinterface

// ----- hw/rtl/ctc_lexer.sv -----
// ----------------------------------------------------------------------------
// ctc_lexer
// token state and classification, up to two results per character
// ----------------------------------------------------------------------------
module ctc_lexer import ctc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     advance,
	input  logic [7:0] byte_s1,
	input  logic     eot_s1,
	output lex_out_t lex
);

	logic [NUM_KW-1:0] alive_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [3:0]        shape_q;

	logic [NUM_KW-1:0] alive_app;
	logic [CNT_W-1:0]  cnt_app;
	logic [3:0]        shape_app;
	logic              kw_hit;
	tok_cls_t          kw_cls;
	tok_cls_t          pend_cls;
	tok_cls_t          spec_cls;
	logic              is_ext;
	logic              is_num;
	logic              is_sep;
	logic              is_spec;
	logic              pending;
	logic              clear;
	logic              append;
	logic              digit;
	res_t              pend_res;

	// classify the pending token
	always_comb begin
		kw_hit = 1'b0;
		kw_cls = CLS_OTHER;
		for (int k = 0; k < NUM_KW; k++) begin
			if (!kw_hit && alive_q[k] && cnt_q == CNT_W'(KW_LEN[k])) begin
				kw_hit = 1'b1;
				kw_cls = KW_CLS[k];
			end
		end
		is_ext = (cnt_q > CNT_W'(1)) && shape_q[SH_DOT0] && !shape_q[SH_DOT2];
		is_num = (cnt_q != '0) && shape_q[SH_DIGITS] && !shape_q[SH_ZERO0];
		priority if (kw_hit && kw_cls <= CLS_DEFAULT) begin
			pend_cls = kw_cls;
		end else if (is_ext) begin
			pend_cls = CLS_EXTENSION;
		end else if (kw_hit) begin
			pend_cls = kw_cls;
		end else if (is_num) begin
			pend_cls = CLS_NUMBER;
		end else begin
			pend_cls = CLS_OTHER;
		end
	end

	// append one character
	always_comb begin
		digit = (byte_s1 >= CH_ZERO) && (byte_s1 <= CH_NINE);
		for (int k = 0; k < NUM_KW; k++) begin
			alive_app[k] = alive_q[k] && (cnt_q < CNT_W'(KW_LEN[k]))
				&& (kw_char(k, cnt_q[KW_IDX_W-1:0]) == byte_s1);
		end
		shape_app = shape_q;
		if (!digit) begin
			shape_app[SH_DIGITS] = 1'b0;
		end
		if (cnt_q == '0) begin
			if (byte_s1 == CH_ZERO) begin
				shape_app[SH_ZERO0] = 1'b1;
			end
			if (byte_s1 == CH_DOT) begin
				shape_app[SH_DOT0] = 1'b1;
			end
		end else if (byte_s1 == CH_DOT) begin
			shape_app[SH_DOT2] = 1'b1;
		end
		cnt_app = (cnt_q < CNT_W'(MAX_LENGTH)) ? cnt_q + CNT_W'(1) : cnt_q;
	end

	// result selection
	always_comb begin
		is_sep  = (byte_s1 == CH_SPACE) || (byte_s1 == CH_NL) || (byte_s1 == CH_TAB);
		is_spec = 1'b1;
		unique case (byte_s1)
			CH_SEMI:   spec_cls = CLS_SEMI;
			CH_LBRACE: spec_cls = CLS_LBRACE;
			CH_RBRACE: spec_cls = CLS_RBRACE;
			default: begin
				spec_cls = CLS_OTHER;
				is_spec  = 1'b0;
			end
		endcase
		pending  = (cnt_q != '0);
		pend_res = '{cls: pend_cls, len: sat_len(cnt_q), last: 1'b0};
		lex      = '{num: 2'd0, r0: pend_res, r1: pend_res};
		clear    = 1'b0;
		append   = 1'b0;
		priority if (eot_s1) begin
			clear = 1'b1;
			if (pending) begin
				lex.num = 2'd2;
				lex.r1  = '{cls: CLS_END, len: '0, last: 1'b1};
			end else begin
				lex.num = 2'd1;
				lex.r0  = '{cls: CLS_END, len: '0, last: 1'b1};
			end
		end else if (is_sep) begin
			clear = 1'b1;
			if (pending) begin
				lex.num     = 2'd1;
				lex.r0.last = 1'b1;
			end
		end else if (is_spec) begin
			clear = 1'b1;
			if (pending) begin
				lex.num = 2'd2;
				lex.r1  = '{cls: spec_cls, len: LEN_W'(1), last: 1'b1};
			end else begin
				lex.num = 2'd1;
				lex.r0  = '{cls: spec_cls, len: LEN_W'(1), last: 1'b1};
			end
		end else begin
			append = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alive_q <= '1;
			cnt_q   <= '0;
			shape_q <= SHAPE_RESET;
		end else if (advance) begin
			if (clear) begin
				alive_q <= '1;
				cnt_q   <= '0;
				shape_q <= SHAPE_RESET;
			end else if (append) begin
				alive_q <= alive_app;
				cnt_q   <= cnt_app;
				shape_q <= shape_app;
			end
		end
	end

endmodule

// ----- hw/rtl/ctc_out_queue.sv -----
// ----------------------------------------------------------------------------
// ctc_out_queue
// result queue, takes up to two results a cycle and gives one
// ----------------------------------------------------------------------------
module ctc_out_queue import ctc_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  lex_out_t            push,
	input  logic                pop,
	output logic                head_valid,
	output res_t                head,
	output logic [OQ_CNT_W-1:0] count
);

	res_t                 mem_q [OQ_DEPTH];
	logic [OQ_PTR_W-1:0]  wr_q;
	logic [OQ_PTR_W-1:0]  rd_q;
	logic [OQ_CNT_W-1:0]  count_q;
	logic [OQ_PTR_W-1:0]  wr_nx;

	assign head_valid = (count_q != '0);
	assign head       = mem_q[rd_q];
	assign count      = count_q;
	assign wr_nx      = wr_q + OQ_PTR_W'(1);

	always_ff @(posedge clk) begin
		if (push.num != 2'd0) begin
			mem_q[wr_q] <= push.r0;
		end
		if (push.num == 2'd2) begin
			mem_q[wr_nx] <= push.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			wr_q    <= wr_q + OQ_PTR_W'(push.num);
			count_q <= count_q + OQ_CNT_W'(push.num) - OQ_CNT_W'(pop);
			if (pop) begin
				rd_q <= rd_q + OQ_PTR_W'(1);
			end
		end
	end

endmodule

// ----- hw/rtl/config_token_classifier_top.sv -----
// ----------------------------------------------------------------------------
// config_token_classifier_top
// splits a configuration byte stream into tokens and classifies each one
//
//   channel  dir  fields                               transaction
//   in_ch    in   byte_in, end_of_text                 one character or end
//   out_ch   out  token_class, token_length, last      one token result
//
// one character is taken per cycle while the four-entry result queue has two
// free slots, also a character that yields two results; a character is held in
// the input register, and its results go through the result queue to the output.
// reset clears the token state and the queue; no clearing pass.
// a stalled output fills the queue; input ready drops once under two slots are free.
// ----------------------------------------------------------------------------
module config_token_classifier_top import ctc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	ctc_in_if.sink    in_ch,
	ctc_out_if.source out_ch
);

	logic                valid_s1;
	logic [7:0]          byte_s1;
	logic                eot_s1;
	logic                advance;
	logic                pop;
	lex_out_t            lex;
	lex_out_t            push;
	res_t                head;
	logic                head_valid;
	logic [OQ_CNT_W-1:0] count;

	assign advance     = valid_s1 && (count <= OQ_CNT_W'(OQ_DEPTH - 2));
	assign in_ch.ready = !valid_s1 || advance;
	assign pop         = head_valid && out_ch.ready;

	always_comb begin
		push = lex;
		if (!advance) begin
			push.num = 2'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			byte_s1 <= in_ch.byte_in;
			eot_s1  <= in_ch.end_of_text;
		end
	end

	ctc_lexer u_lexer (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.byte_s1 (byte_s1),
		.eot_s1  (eot_s1),
		.lex     (lex)
	);

	ctc_out_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head),
		.count      (count)
	);

	assign out_ch.valid        = head_valid;
	assign out_ch.token_class  = head.cls;
	assign out_ch.token_length = head.len;
	assign out_ch.last         = head.last;

endmodule

// ----- hw/rtl/ctc_checker.sv -----
// ----------------------------------------------------------------------------
// ctc_checker
// port-level checks of the configuration token classifier
// ----------------------------------------------------------------------------
`include "config_token_classifier_top_macros.svh"

module ctc_checker import ctc_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             out_valid,
	input logic             out_ready,
	input logic [CLS_W-1:0] token_class,
	input logic [LEN_W-1:0] token_length,
	input logic             last
);

	`CTC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(token_class) && $stable(token_length) && $stable(last), "stalled result changed")
	`CTC_ASSERT_NOW(a_end_token, out_valid && token_class == CLS_END, last && token_length == '0, "bad end token")
	`CTC_ASSERT_NOW(a_single_char, out_valid && (token_class == CLS_SEMI || token_class == CLS_LBRACE || token_class == CLS_RBRACE), last && token_length == LEN_W'(1), "bad single-char token")
	`CTC_ASSERT_NOW(a_class_len, out_valid, token_class <= CLS_OTHER && (token_class == CLS_END || token_length != '0), "bad class or empty token")

endmodule

bind config_token_classifier_top ctc_checker u_ctc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_ch.valid),
	.out_ready    (out_ch.ready),
	.token_class  (out_ch.token_class),
	.token_length (out_ch.token_length),
	.last         (out_ch.last)
);

// ----- bench/config_token_classifier_top_tb.sv -----
// ----------------------------------------------------------------------------
// config_token_classifier_top_tb
// self-checking bench for the configuration token classifier
//
// a directed run covers separators, special characters, number and
// extension shapes, edge byte values and end of text. A random run follows,
// made mostly of keywords (whole, cut short or extended), numbers,
// extensions and plain words, with noise bytes, long saturating tokens and
// end-of-text marks mixed in. A scoreboard predicts every token result and
// checks the output stream in order. Both sides idle at random, with one
// stretch free of idling and one long output stall.
// ----------------------------------------------------------------------------
module config_token_classifier_top_tb;
	import ctc_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	class token_scoreboard;
		string       kw_text [NUM_KW];
		tok_cls_t    kw_class [NUM_KW];
		logic [16:0] alive;
		int unsigned count;
		logic [3:0]  shape;
		res_t        expected_tokens[$];
		int          errors;

		function new();
			kw_text[0]  = {string'("server_"), "name"};
			kw_class[0]  = CLS_SRV_NAME;
			kw_text[1]  = "listen";               kw_class[1]  = CLS_LISTEN;
			kw_text[2]  = {string'("error_"), "page"};
			kw_class[2]  = CLS_ERR_PAGE;
			kw_text[3]  = {string'("client_body_"), "size_max"};
			kw_class[3]  = CLS_BODY_MAX;
			kw_text[4]  = "location";             kw_class[4]  = CLS_LOCATION;
			kw_text[5]  = {string'("allow_"), "methods"};
			kw_class[5]  = CLS_ALLOW;
			kw_text[6]  = "GET";                  kw_class[6]  = CLS_METHOD;
			kw_text[7]  = "POST";                 kw_class[7]  = CLS_METHOD;
			kw_text[8]  = "DELETE";               kw_class[8]  = CLS_METHOD;
			kw_text[9]  = "redirect";             kw_class[9]  = CLS_REDIRECT;
			kw_text[10] = "root";                 kw_class[10] = CLS_ROOT;
			kw_text[11] = "autoindex";            kw_class[11] = CLS_AUTOINDEX;
			kw_text[12] = "on";                   kw_class[12] = CLS_ON_OFF;
			kw_text[13] = "off";                  kw_class[13] = CLS_ON_OFF;
			kw_text[14] = "default";              kw_class[14] = CLS_DEFAULT;
			kw_text[15] = "cgi";                  kw_class[15] = CLS_CGI;
			kw_text[16] = "upload";               kw_class[16] = CLS_UPLOAD;
			errors = 0;
			clear_token();
		endfunction

		function void clear_token();
			alive = '1;
			count = 0;
			shape = SHAPE_RESET;
		endfunction

		function tok_cls_t token_class_of();
			tok_cls_t kw;
			bit       found;
			bit       is_ext;
			bit       is_num;
			kw = CLS_END;
			found = 0;
			for (int k = 0; k < NUM_KW; k++) begin
				if (!found && alive[k] && count == kw_text[k].len()) begin
					kw = kw_class[k];
					found = 1;
				end
			end
			is_ext = count > 1 && shape[SH_DOT0] && !shape[SH_DOT2];
			is_num = count > 0 && shape[SH_DIGITS] && !shape[SH_ZERO0];
			// keywords through default outrank extension, cgi/upload do not
			if (found && kw <= CLS_DEFAULT) return kw;
			if (is_ext) return CLS_EXTENSION;
			if (found) return kw;
			if (is_num) return CLS_NUMBER;
			return CLS_OTHER;
		endfunction

		function void add_token(tok_cls_t cls, int unsigned len, logic last);
			res_t r;
			r.cls = cls;
			r.len = (len > 255) ? 8'hFF : LEN_W'(len);
			r.last = last;
			expected_tokens.push_back(r);
		endfunction

		function void take_char(logic [7:0] c, logic eot);
			tok_cls_t spec;
			int unsigned pos;
			if (eot) begin
				if (count > 0) add_token(token_class_of(), count, 1'b0);
				add_token(CLS_END, 0, 1'b1);
				clear_token();
				return;
			end
			if (c == CH_SPACE || c == CH_NL || c == CH_TAB) begin
				if (count > 0) begin
					add_token(token_class_of(), count, 1'b1);
					clear_token();
				end
				return;
			end
			spec = CLS_END;
			if (c == CH_SEMI) spec = CLS_SEMI;
			else if (c == CH_LBRACE) spec = CLS_LBRACE;
			else if (c == CH_RBRACE) spec = CLS_RBRACE;
			if (spec != CLS_END) begin
				if (count > 0) begin
					add_token(token_class_of(), count, 1'b0);
					clear_token();
				end
				add_token(spec, 1, 1'b1);
				return;
			end
			pos = count;
			for (int k = 0; k < NUM_KW; k++) begin
				if (!(pos < kw_text[k].len() && kw_text[k][pos] == c)) alive[k] = 1'b0;
			end
			if (c < CH_ZERO || c > CH_NINE) shape[SH_DIGITS] = 1'b0;
			if (pos == 0) begin
				if (c == CH_ZERO) shape[SH_ZERO0] = 1'b1;
				if (c == CH_DOT) shape[SH_DOT0] = 1'b1;
			end else if (c == CH_DOT) begin
				shape[SH_DOT2] = 1'b1;
			end
			if (count < MAX_LENGTH) count++;
		endfunction

		function void check_token(logic [CLS_W-1:0] cls, logic [LEN_W-1:0] len, logic last);
			res_t e;
			if (expected_tokens.size() == 0) begin
				$error("unexpected token result: class %0d length %0d last %0b", cls, len, last);
				errors++;
				return;
			end
			e = expected_tokens.pop_front();
			if (cls !== e.cls) begin
				$error("token_class mismatch: expected %0d, actual %0d", e.cls, cls);
				errors++;
			end
			if (len !== e.len) begin
				$error("token_length mismatch: expected %0d, actual %0d", e.len, len);
				errors++;
			end
			if (last !== e.last) begin
				$error("last mismatch: expected %0b, actual %0b", e.last, last);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	bit   calm;
	bit   hold_go;
	int   items_sent;

	token_scoreboard sb;

	ctc_in_if  in_ch();
	ctc_out_if out_ch();

	config_token_classifier_top uut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	function automatic logic [7:0] rand_word_byte();
		logic [7:0] c;
		do begin
			c = 8'($urandom_range(255));
		end while (c == CH_SPACE || c == CH_NL || c == CH_TAB || c == CH_SEMI ||
			c == CH_LBRACE || c == CH_RBRACE);
		return c;
	endfunction

	task automatic send_item(input logic [7:0] c, input logic eot);
		while (!calm && $urandom_range(99) < 12) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.byte_in <= c;
		in_ch.end_of_text <= eot;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		sb.take_char(c, eot);
		items_sent++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
	endtask

	// output side: random stalls, one long hold-off
	initial begin
		int  hold_left;
		bit  hold_done;
		hold_left = 0;
		hold_done = 0;
		out_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_go && !hold_done) begin
				hold_done = 1;
				hold_left = 300;
			end
			if (hold_left > 0) begin
				out_ch.ready <= 1'b0;
				hold_left--;
			end else if (calm) begin
				out_ch.ready <= 1'b1;
			end else begin
				out_ch.ready <= ($urandom_range(99) >= 12);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready) begin
			sb.check_token(out_ch.token_class, out_ch.token_length, out_ch.last);
		end
	end

	initial begin
		#5_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		int         pick;
		int         n;
		int         k;
		int         mode;
		int         word_idx;
		int         guard;
		logic [7:0] c;
		sb = new();
		calm = 0;
		hold_go = 0;
		items_sent = 0;
		word_idx = 0;
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.byte_in = 8'h00;
		in_ch.end_of_text = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed transactions
		send_item(CH_SPACE, 1'b0);
		send_text("on;");
		send_text("07\t");
		send_text(".c{");
		send_text(".\n");
		send_text("9}");
		send_item(8'hFF, 1'b0);
		send_item(8'h00, 1'b0);
		send_item(CH_TAB, 1'b0);
		send_text("a.b ");
		send_item(8'h00, 1'b1);
		send_text("x");
		send_item(8'hFF, 1'b1);

		// random token stream
		while (items_sent < 775) begin
			word_idx++;
			if (items_sent >= 300) hold_go = 1;
			calm = (items_sent >= 500 && items_sent < 620);
			pick = $urandom_range(99);
			if (word_idx == 30 || word_idx == 160) begin
				n = $urandom_range(300, 250);
				mode = $urandom_range(2);
				for (int i = 0; i < n; i++) begin
					if (mode == 0) c = (i == 0) ? CH_DOT : rand_word_byte();
					else if (mode == 1) c = 8'($urandom_range(CH_NINE, CH_ZERO + 1));
					else c = rand_word_byte();
					send_item(c, 1'b0);
				end
			end else if (pick < 35) begin
				k = $urandom_range(NUM_KW - 1);
				n = sb.kw_text[k].len();
				mode = $urandom_range(3);
				if (mode == 0) n = $urandom_range(n, 1);
				for (int i = 0; i < n; i++) send_item(sb.kw_text[k][i], 1'b0);
				if (mode == 1) send_item(rand_word_byte(), 1'b0);
			end else if (pick < 50) begin
				n = $urandom_range(6, 1);
				for (int i = 0; i < n; i++) begin
					if (i == 0 && $urandom_range(4) != 0)
						c = 8'($urandom_range(CH_NINE, CH_ZERO + 1));
					else c = 8'($urandom_range(CH_NINE, CH_ZERO));
					send_item(c, 1'b0);
				end
			end else if (pick < 62) begin
				send_item(CH_DOT, 1'b0);
				n = $urandom_range(5, 0);
				for (int i = 0; i < n; i++) begin
					c = ($urandom_range(7) == 0) ? CH_DOT : 8'($urandom_range(8'h7A, 8'h61));
					send_item(c, 1'b0);
				end
			end else if (pick < 77) begin
				n = $urandom_range(8, 1);
				for (int i = 0; i < n; i++) send_item(rand_word_byte(), 1'b0);
			end else if (pick < 87) begin
				n = $urandom_range(4, 1);
				for (int i = 0; i < n; i++) begin
					send_item(8'($urandom_range(255)), ($urandom_range(9) == 0));
				end
			end else if (pick < 91) begin
				send_item(8'($urandom_range(255)), 1'b1);
			end
			case ($urandom_range(9))
				0, 1: ;
				2, 3: send_item(CH_SPACE, 1'b0);
				4: send_item(CH_NL, 1'b0);
				5: send_item(CH_TAB, 1'b0);
				6: send_item(CH_SEMI, 1'b0);
				7: send_item(CH_LBRACE, 1'b0);
				8: send_item(CH_RBRACE, 1'b0);
				default: begin
					send_item(CH_SPACE, 1'b0);
					send_item(CH_SEMI, 1'b0);
				end
			endcase
		end
		calm = 0;
		in_ch.valid <= 1'b0;

		guard = 0;
		while (sb.expected_tokens.size() != 0 && guard < 5000) begin
			@(posedge clk);
			guard++;
		end
		repeat (20) @(posedge clk);
		if (sb.expected_tokens.size() != 0) begin
			$error("%0d expected token results never arrived", sb.expected_tokens.size());
			sb.errors++;
		end
		if (sb.errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/ctc_pkg.sv
hw/rtl/ctc_if.sv
hw/rtl/ctc_lexer.sv
hw/rtl/ctc_out_queue.sv
hw/rtl/config_token_classifier_top.sv
hw/rtl/ctc_checker.sv
bench/config_token_classifier_top_tb.sv
